FILE: rtl/gfnm_pkg.sv
// ----------------------------------------------------------------------------
// gfnm_pkg
// Shared types, codes and constants for the grid gap-fill block.
// ----------------------------------------------------------------------------
package gfnm_pkg;

   localparam int MAX_DIM_DEF   = 64;
   localparam int MAX_CELLS_DEF = 4096;

   localparam int VAL_W   = 32;  // Q16.16 sample
   localparam int IDX_W   = 12;  // cell_index field
   localparam int CNT_W   = 4;   // valid-neighbor count, 0..9
   localparam int SUM_W   = 36;  // signed sum of up to nine samples
   localparam int MAG_W   = 35;  // magnitude of that sum
   localparam int MISS_W  = 13;  // missing_left field
   localparam int DIM_CFG_W  = 7;
   localparam int THR_W      = 16;
   localparam int PASS_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FILL  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMN_COUNT = 2'd0,
      CSR_ROW_COUNT    = 2'd1,
      CSR_THRESHOLD    = 2'd2,
      CSR_PASS_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [IDX_W-1:0]        cell_index;
      logic signed [VAL_W-1:0] sample_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic                    cell_missing;
      logic [MISS_W-1:0]       missing_left;
   } rsp_payload_type;

   typedef struct packed {
      logic rd_en;
      logic grid_we;
      logic flag_we;
      logic flag_bit;
   } store_ctl_type;

   // Below threshold*65536 is the same as the integer part being below threshold.
   function automatic logic is_below(input logic [VAL_W-1:0] value,
                                     input logic signed [THR_W-1:0] thr);
      return $signed(value[VAL_W-1:VAL_W-THR_W]) < thr;
   endfunction

endpackage

FILE: rtl/gfnm_div.sv
// ----------------------------------------------------------------------------
// gfnm_div
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
// ----------------------------------------------------------------------------
module gfnm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gfnm_pkg::MAG_W-1:0]   dividend,
   input  logic [gfnm_pkg::CNT_W-1:0]   divisor,
   output logic                         done,
   output logic [gfnm_pkg::MAG_W-1:0]   quotient
);
   localparam int STEP_W = $clog2(gfnm_pkg::MAG_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [STEP_W-1:0]           step_ff;
   logic [gfnm_pkg::CNT_W-1:0]  rem_ff;
   logic [gfnm_pkg::MAG_W-1:0]  quo_ff;
   logic [gfnm_pkg::CNT_W-1:0]  div_ff;
   logic [gfnm_pkg::CNT_W:0]    shift_in;
   logic                        fit_in;

   assign shift_in = {rem_ff, quo_ff[gfnm_pkg::MAG_W-1]};
   assign fit_in   = shift_in >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fit_in ? gfnm_pkg::CNT_W'(shift_in - {1'b0, div_ff})
                             : gfnm_pkg::CNT_W'(shift_in);
            quo_ff <= {quo_ff[gfnm_pkg::MAG_W-2:0], fit_in};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(gfnm_pkg::MAG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: rtl/gfnm_store.sv
// ----------------------------------------------------------------------------
// gfnm_store
// Sample memory and per-pass fill marks, one read and one write port each.
// ----------------------------------------------------------------------------
module gfnm_store #(
   parameter int MAX_CELLS = gfnm_pkg::MAX_CELLS_DEF,
   parameter int AW        = $clog2(MAX_CELLS)
) (
   input  logic                         clock,
   input  gfnm_pkg::store_ctl_type      ctl,
   input  logic [AW-1:0]                rd_addr,
   input  logic [AW-1:0]                wr_addr,
   input  logic [gfnm_pkg::VAL_W-1:0]   wr_data,
   output logic [gfnm_pkg::VAL_W-1:0]   rd_grid,
   output logic                         rd_filled
);
   logic [gfnm_pkg::VAL_W-1:0] grid_mem [MAX_CELLS];
   logic                       flag_mem [MAX_CELLS];
   logic [gfnm_pkg::VAL_W-1:0] rd_grid_ff;
   logic                       rd_filled_ff;

   always_ff @(posedge clock) begin
      if (ctl.grid_we) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (ctl.flag_we) begin
         flag_mem[wr_addr] <= ctl.flag_bit;
      end
      if (ctl.rd_en) begin
         rd_grid_ff   <= grid_mem[rd_addr];
         rd_filled_ff <= flag_mem[rd_addr];
      end
   end

   assign rd_grid   = rd_grid_ff;
   assign rd_filled = rd_filled_ff;
endmodule

FILE: rtl/grid_gap_fill_neighbor_mean.sv
// ----------------------------------------------------------------------------
// grid_gap_fill_neighbor_mean
// Grid of Q16.16 samples with write, read-back and iterative 3x3 gap fill.
// ----------------------------------------------------------------------------
// Fill pass: S_CLEAR drops the fill marks of the cells in use, then each cell is read
//   (S_CRD, S_CCHK); a missing cell walks its window (S_WRD, S_WACC) and, when a
//   neighbor is valid, runs the divider (S_DIVGO, S_DIV). A zero pass limit skips
//   the clear and only counts missing cells.
// Throughput: one item at a time; the single memory read port and the divider set
//   the fill time. Reset: config to defaults, count cleared, samples undefined.
module grid_gap_fill_neighbor_mean #(
   parameter int MAX_DIM   = gfnm_pkg::MAX_DIM_DEF,
   parameter int MAX_CELLS = gfnm_pkg::MAX_CELLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gfnm_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gfnm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gfnm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gfnm_pkg::CSR_DATA_W-1:0]      csr_data
);
   localparam int AW   = $clog2(MAX_CELLS);
   localparam int DIMW = $clog2(MAX_DIM + 1);
   localparam int LINW = 2 * DIMW;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CLEAR, S_CRD, S_CCHK, S_WRD, S_WACC, S_DIVGO, S_DIV
   } state_type;

   // configuration
   logic [gfnm_pkg::DIM_CFG_W-1:0]     cols_cfg_ff, rows_cfg_ff;
   logic signed [gfnm_pkg::THR_W-1:0]  thr_ff;
   logic [gfnm_pkg::PASS_W-1:0]        plim_ff;

   // control
   state_type                          state_ff;
   logic                               rsp_valid_ff;
   gfnm_pkg::rsp_payload_type          rsp_ff;
   logic [gfnm_pkg::MISS_W-1:0]        missing_count_ff;
   logic [gfnm_pkg::MISS_W-1:0]        miss_ff;
   logic [gfnm_pkg::PASS_W-1:0]        pass_ff;
   logic                               count_only_ff;

   // cell and window walk
   logic [LINW-1:0]                    lin_ff, wbase_ff;
   logic [DIMW-1:0]                    r_ff, c_ff, rr_ff, cc_ff;
   logic signed [gfnm_pkg::SUM_W-1:0]  sum_ff;
   logic [gfnm_pkg::CNT_W-1:0]         n_ff;
   logic                               j_ok_ff;

   logic [DIMW-1:0]                    cols, rows, r_lo, r_hi, c_lo, c_hi;
   logic [LINW-1:0]                    used, j_lin;
   logic                               req_fire, idx_ok, cell_in, j_in, lin_last;
   logic                               miss_c, take, adv, miss_inc, pass_end, finish;
   logic [gfnm_pkg::MISS_W-1:0]        miss_nx;
   logic                               div_start, div_done, sum_neg;
   logic [gfnm_pkg::MAG_W-1:0]         div_mag, div_quo, fill_mag;
   gfnm_pkg::store_ctl_type            st_ctl;
   logic [AW-1:0]                      rd_addr, wr_addr;
   logic [gfnm_pkg::VAL_W-1:0]         wr_data, rd_grid;
   logic                               rd_filled;

   // Clamp dimensions: zero acts as one, above MAX_DIM saturates.
   always_comb begin
      cols = (cols_cfg_ff == '0) ? DIMW'(1) :
             (32'(cols_cfg_ff) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(cols_cfg_ff);
      rows = (rows_cfg_ff == '0) ? DIMW'(1) :
             (32'(rows_cfg_ff) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(rows_cfg_ff);
   end

   assign used     = LINW'(cols) * LINW'(rows);
   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign idx_ok    = (32'(req_payload.cell_index) < 32'(used)) &&
                      (32'(req_payload.cell_index) < MAX_CELLS);

   // 3x3 window clipped at the grid edges
   assign r_lo = (r_ff == '0) ? '0 : r_ff - 1'b1;
   assign c_lo = (c_ff == '0) ? '0 : c_ff - 1'b1;
   assign r_hi = (32'(r_ff) + 1 >= 32'(rows)) ? r_ff : r_ff + 1'b1;
   assign c_hi = (32'(c_ff) + 1 >= 32'(cols)) ? c_ff : c_ff + 1'b1;

   assign j_lin    = wbase_ff + LINW'(cc_ff);
   assign j_in     = 32'(j_lin) < MAX_CELLS;
   assign cell_in  = 32'(lin_ff) < MAX_CELLS;
   assign lin_last = lin_ff == used - 1'b1;
   assign miss_c   = gfnm_pkg::is_below(rd_grid, thr_ff);
   // A neighbor counts only if it was valid at the start of the pass.
   assign take     = j_ok_ff && !rd_filled && !miss_c;

   // Advance to the next cell, and count cells that stay missing.
   always_comb begin
      adv      = 1'b0;
      miss_inc = 1'b0;
      unique case (state_ff)
         S_CRD:   adv = !cell_in;
         S_CCHK: begin
            adv      = !miss_c || count_only_ff;
            miss_inc = miss_c && count_only_ff;
         end
         S_DIVGO: begin
            adv      = n_ff == '0;
            miss_inc = n_ff == '0;
         end
         S_DIV:   adv = div_done;
         default: adv = 1'b0;
      endcase
   end

   assign miss_nx  = miss_ff + gfnm_pkg::MISS_W'(miss_inc);
   assign pass_end = adv && lin_last;
   assign finish   = pass_end && (count_only_ff || miss_nx == '0 ||
                     ({1'b0, pass_ff} + 1'b1) == {1'b0, plim_ff});

   // Shared divider: mean = |sum| / n, sign restored afterwards.
   assign sum_neg   = sum_ff[gfnm_pkg::SUM_W-1];
   assign div_mag   = gfnm_pkg::MAG_W'(sum_neg ? -sum_ff : sum_ff);
   assign div_start = (state_ff == S_DIVGO) && (n_ff != '0);
   assign fill_mag  = sum_neg ? -div_quo : div_quo;

   gfnm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Memory port control
   always_comb begin
      st_ctl.rd_en    = (req_fire && req_payload.opcode == gfnm_pkg::OP_READ && idx_ok) ||
                        (state_ff == S_CRD && cell_in) || (state_ff == S_WRD && j_in);
      st_ctl.grid_we  = (req_fire && req_payload.opcode == gfnm_pkg::OP_WRITE && idx_ok) ||
                        (state_ff == S_DIV && div_done);
      st_ctl.flag_we  = (state_ff == S_CLEAR && cell_in) || (state_ff == S_DIV && div_done);
      st_ctl.flag_bit = state_ff == S_DIV;
      priority case (state_ff)
         S_CRD:   rd_addr = AW'(lin_ff);
         S_WRD:   rd_addr = AW'(j_lin);
         default: rd_addr = AW'(req_payload.cell_index);
      endcase
      if (state_ff == S_IDLE) begin
         wr_addr = AW'(req_payload.cell_index);
         wr_data = req_payload.sample_value;
      end else begin
         wr_addr = AW'(lin_ff);
         wr_data = gfnm_pkg::VAL_W'(fill_mag);
      end
   end

   gfnm_store #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_store (
      .clock     (clock),
      .ctl       (st_ctl),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_grid   (rd_grid),
      .rd_filled (rd_filled)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= gfnm_pkg::DIM_CFG_W'(64);
         rows_cfg_ff <= gfnm_pkg::DIM_CFG_W'(64);
         thr_ff      <= '0;
         plim_ff     <= gfnm_pkg::PASS_W'(2);
      end else if (csr_valid) begin
         unique case (csr_index)
            gfnm_pkg::CSR_COLUMN_COUNT: cols_cfg_ff <= csr_data[gfnm_pkg::DIM_CFG_W-1:0];
            gfnm_pkg::CSR_ROW_COUNT:    rows_cfg_ff <= csr_data[gfnm_pkg::DIM_CFG_W-1:0];
            gfnm_pkg::CSR_THRESHOLD:    thr_ff      <= $signed(csr_data);
            gfnm_pkg::CSR_PASS_LIMIT:   plim_ff     <= csr_data[gfnm_pkg::PASS_W-1:0];
            default:                    plim_ff     <= plim_ff;
         endcase
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         missing_count_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rsp_ff.read_value   <= '0;
                  rsp_ff.cell_missing <= 1'b0;
                  rsp_ff.missing_left <= missing_count_ff;
                  priority if (req_payload.opcode == gfnm_pkg::OP_FILL) begin
                     lin_ff        <= '0;
                     r_ff          <= '0;
                     c_ff          <= '0;
                     miss_ff       <= '0;
                     pass_ff       <= '0;
                     count_only_ff <= plim_ff == '0;
                     state_ff      <= (plim_ff == '0) ? S_CRD : S_CLEAR;
                  end else if (req_payload.opcode == gfnm_pkg::OP_READ && idx_ok) begin
                     state_ff <= S_READ;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               rsp_ff.read_value   <= rd_grid;
               rsp_ff.cell_missing <= miss_c;
               rsp_valid_ff        <= 1'b1;
               state_ff            <= S_IDLE;
            end
            S_CLEAR: begin
               // drop the fill marks of the previous pass
               lin_ff <= lin_ff + 1'b1;
               if (lin_last) begin
                  lin_ff   <= '0;
                  r_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= S_CRD;
               end
            end
            S_CRD: state_ff <= S_CCHK;
            S_CCHK: begin
               rr_ff    <= r_lo;
               cc_ff    <= c_lo;
               wbase_ff <= lin_ff - LINW'(c_ff) - ((r_ff != '0) ? LINW'(cols) : '0);
               sum_ff   <= '0;
               n_ff     <= '0;
               state_ff <= S_WRD;
            end
            S_WRD: begin
               j_ok_ff  <= j_in;
               state_ff <= S_WACC;
            end
            S_WACC: begin
               if (take) begin
                  sum_ff <= sum_ff + gfnm_pkg::SUM_W'($signed(rd_grid));
                  n_ff   <= n_ff + 1'b1;
               end
               state_ff <= S_WRD;
               if (cc_ff == c_hi) begin
                  if (rr_ff == r_hi) begin
                     state_ff <= S_DIVGO;
                  end else begin
                     rr_ff    <= rr_ff + 1'b1;
                     cc_ff    <= c_lo;
                     wbase_ff <= wbase_ff + LINW'(cols);
                  end
               end else begin
                  cc_ff <= cc_ff + 1'b1;
               end
            end
            S_DIVGO: state_ff <= S_DIV;
            S_DIV:   state_ff <= S_DIV;
            default: state_ff <= S_IDLE;
         endcase

         // advance to the next cell; close the pass after the last one
         if (adv) begin
            miss_ff  <= miss_nx;
            lin_ff   <= lin_ff + 1'b1;
            state_ff <= S_CRD;
            if (c_ff == cols - 1'b1) begin
               c_ff <= '0;
               r_ff <= r_ff + 1'b1;
            end else begin
               c_ff <= c_ff + 1'b1;
            end
            if (pass_end) begin
               missing_count_ff <= miss_nx;
               if (finish) begin
                  rsp_ff.read_value   <= '0;
                  rsp_ff.cell_missing <= 1'b0;
                  rsp_ff.missing_left <= miss_nx;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end else begin
                  pass_ff  <= pass_ff + 1'b1;
                  lin_ff   <= '0;
                  miss_ff  <= '0;
                  state_ff <= S_CLEAR;
               end
            end
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

FILE: rtl/gfnm_checker.sv
// ----------------------------------------------------------------------------
// gfnm_checker
// Port-level checks on the gap-fill block, bound to the top level.
// ----------------------------------------------------------------------------
module gfnm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input gfnm_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input gfnm_pkg::rsp_payload_type rsp_payload
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while result register is full");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_payload.opcode == gfnm_pkg::OP_WRITE || req_payload.opcode == gfnm_pkg::OP_NONE)
      |=> rsp_valid && rsp_payload.read_value == '0 && !rsp_payload.cell_missing)
      else $error("write or unused opcode gave a wrong result");

   a_fill_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.opcode == gfnm_pkg::OP_FILL
      |=> !req_ready && !rsp_valid)
      else $error("fill run did not hold off new items");
endmodule

bind grid_gap_fill_neighbor_mean gfnm_checker u_gfnm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
